// ----- rtl/bmfa_pkg.sv -----
// Shared types for the byte memory with frame allocator.
// Request and response words, operation and status codes, and the internal command word.
// No dependencies.
`default_nettype none

package bmfa_pkg;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_TAKE   = 2'd2,
        OP_RETURN = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op        operation;
        logic [15:0] byte_address;
        logic [7:0] write_byte;
        logic [7:0] returned_frame;
    } t_req;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [7:0] granted_frame;
        t_status    status;
    } t_rsp;

    // Request after classification by the front end.
    typedef struct packed {
        t_req req;
        logic addr_ok;
    } t_cmd;

    localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

// ----- rtl/bmfa_front.sv -----
// Front end: accepts request words, checks the address range and queues them.
// Depends on bmfa_pkg.
`default_nettype none

module bmfa_front import bmfa_pkg::*; #(
    parameter int MEM_BYTES = 65536
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    output logic      full,
    input  wire t_req i_req,
    input  wire logic i_hold,
    output logic      o_cmd_valid,
    output t_cmd      o_cmd,
    input  wire logic i_cmd_pop
);

    t_cmd       r_q [QUEUE_DEPTH];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push_fire;
    t_cmd       cmd_in;

    always_comb begin
        cmd_in.req     = i_req;
        cmd_in.addr_ok = (32'(i_req.byte_address) < MEM_BYTES);
    end

    // No request is taken while the back end sweeps the memory after reset.
    assign full        = (r_cnt == 2'(QUEUE_DEPTH)) || i_hold;
    assign push_fire   = push && !full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_wp  = push_fire ? !r_wp : r_wp;
        n_rp  = i_cmd_pop ? !r_rp : r_rp;
        n_cnt = r_cnt + 2'(push_fire) - 2'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_fire) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bmfa_back.sv -----
// Back end: byte memory, free-frame stack, result stage and result queue.
// Depends on bmfa_pkg; fed by bmfa_front.
`default_nettype none

module bmfa_back import bmfa_pkg::*; #(
    parameter int MEM_BYTES  = 65536,
    parameter int PAGE_BYTES = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    output logic      o_hold,
    output logic      empty,
    input  wire logic pop,
    output t_rsp      o_rsp
);

    localparam int MEM_DEPTH  = (MEM_BYTES < 65536) ? MEM_BYTES : 65536;
    localparam int AW         = $clog2(MEM_DEPTH);
    localparam int NUM_FRAMES = MEM_BYTES / PAGE_BYTES;
    localparam int SDEPTH     = (NUM_FRAMES > 0) ? NUM_FRAMES : 1;
    localparam int SW         = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
    localparam int CW         = (NUM_FRAMES == 0) ? 1 : $clog2(NUM_FRAMES + 1);

    logic [7:0] r_mem [MEM_DEPTH];
    logic [7:0] r_stk [SDEPTH];

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_low, n_low;
    logic [CW-1:0] cnt_m1;
    logic          take_ok;
    logic          ret_ok;
    logic          issue;
    logic [AW-1:0] addr_idx;
    logic [7:0]    init_val;

    logic       r_s2_valid;
    t_op        r_s2_op;
    t_status    r_s2_status;
    logic       r_s2_rd_ok;
    logic       r_s2_use_init;
    logic [7:0] r_s2_init;
    logic [7:0] r_mem_q;
    logic [7:0] r_stk_q;
    t_rsp       s2_rsp;

    t_rsp       r_out [QUEUE_DEPTH];
    logic       r_owp;
    logic       r_orp;
    logic [1:0] r_ocnt;
    logic       pop_fire;

    assign pop_fire = pop && !empty;
    assign empty    = (r_ocnt == 2'd0);
    assign o_rsp    = r_out[r_orp];
    assign o_hold   = r_clr_busy;

    // Issue only when the result queue can still take the item in flight and this one.
    assign issue = i_cmd_valid && !r_clr_busy &&
                   ((r_ocnt + 2'(r_s2_valid)) <= (2'd1 + 2'(pop_fire)));
    assign o_cmd_pop = issue;

    assign addr_idx = i_cmd.req.byte_address[AW-1:0];
    assign cnt_m1   = r_cnt - CW'(1);
    assign take_ok  = (r_cnt != CW'(0));
    assign ret_ok   = (r_cnt < CW'(NUM_FRAMES));
    assign init_val = 8'(NUM_FRAMES - 1 - 32'(cnt_m1));

    // Slots below the low-water mark have never been pushed since reset,
    // so they still hold their reset frame number, which is computed.
    always_comb begin
        n_cnt = r_cnt;
        n_low = r_low;
        if (issue) begin
            unique case (i_cmd.req.operation)
                OP_TAKE: begin
                    if (take_ok) begin
                        n_cnt = cnt_m1;
                        if (cnt_m1 < r_low) begin
                            n_low = cnt_m1;
                        end
                    end
                end
                OP_RETURN: begin
                    if (ret_ok) begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_cnt      <= CW'(NUM_FRAMES);
            r_low      <= CW'(NUM_FRAMES);
            r_s2_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(MEM_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_cnt      <= n_cnt;
            r_low      <= n_low;
            r_s2_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_op       <= i_cmd.req.operation;
        r_s2_rd_ok    <= i_cmd.addr_ok;
        r_s2_use_init <= (cnt_m1 < r_low);
        r_s2_init     <= init_val;
        case (i_cmd.req.operation)
            OP_TAKE:   r_s2_status <= take_ok ? ST_OK : ST_EMPTY;
            OP_RETURN: r_s2_status <= ret_ok ? ST_OK : ST_FULL;
            default:   r_s2_status <= ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= 8'd0;
        end else if (issue && i_cmd.req.operation == OP_WRITE && i_cmd.addr_ok) begin
            r_mem[addr_idx] <= i_cmd.req.write_byte;
        end
        r_mem_q <= r_mem[addr_idx];
    end

    always_ff @(posedge i_clk) begin
        if (issue && i_cmd.req.operation == OP_RETURN && ret_ok) begin
            r_stk[SW'(r_cnt)] <= i_cmd.req.returned_frame;
        end
        r_stk_q <= r_stk[SW'(cnt_m1)];
    end

    always_comb begin
        s2_rsp.read_byte     = (r_s2_op == OP_READ && r_s2_rd_ok) ? r_mem_q : 8'd0;
        s2_rsp.granted_frame = 8'd0;
        if (r_s2_op == OP_TAKE && r_s2_status == ST_OK) begin
            s2_rsp.granted_frame = r_s2_use_init ? r_s2_init : r_stk_q;
        end
        s2_rsp.status = r_s2_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (r_s2_valid) begin
                r_owp <= !r_owp;
            end
            if (pop_fire) begin
                r_orp <= !r_orp;
            end
            r_ocnt <= r_ocnt + 2'(r_s2_valid) - 2'(pop_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_out[r_owp] <= s2_rsp;
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(NUM_FRAMES))
        else $error("free count beyond frame count");

    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_cnt)
        else $error("low-water mark above free count");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |-> !(r_ocnt == 2'(QUEUE_DEPTH) && !pop_fire))
        else $error("result queue overflow");

    a_no_issue_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !issue)
        else $error("request issued during memory clear");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> r_s2_valid)
        else $error("issued request lost before result stage");

endmodule

`default_nettype wire

// ----- rtl/byte_memory_with_frame_allocator_core.sv -----
// Requests pass front queue, result stage and result queue; one request per cycle unless stalled.
// Throughput is set by the single port of the byte memory and of the free-frame stack.
// After reset the byte memory is swept to zero one byte a cycle, all min(MEM_BYTES, 65536)
// bytes (65536 by default), with full held high; the free-frame stack needs no sweep.
// Top level: bmfa_front queues and classifies requests, bmfa_back executes them.
// Depends on bmfa_pkg, bmfa_front and bmfa_back.
`default_nettype none

module byte_memory_with_frame_allocator_core import bmfa_pkg::*; #(
    parameter int MEM_BYTES  = 65536,
    parameter int PAGE_BYTES = 256
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    output logic      full,
    input  wire t_req i_req,
    output logic      empty,
    input  wire logic pop,
    output t_rsp      o_rsp
);

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;
    logic hold;

    bmfa_front #(
        .MEM_BYTES (MEM_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_req       (i_req),
        .i_hold      (hold),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    bmfa_back #(
        .MEM_BYTES  (MEM_BYTES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_hold      (hold),
        .empty       (empty),
        .pop         (pop),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire
